@@ hdl/servo_response_frame_checker_macros.svh @@
// Assertion macros used by the servo response frame checker assertion file srfc_checker.sv.
`ifndef SERVO_RESPONSE_FRAME_CHECKER_MACROS_SVH
`define SERVO_RESPONSE_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRFC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srfc assertion failed");

// Next-cycle implication, disabled during reset.
`define SRFC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srfc assertion failed");

`endif

@@ hdl/srfc_pkg.sv @@
// Package: constants, codes and widths of the servo response frame checker.
package srfc_pkg;

   localparam int MAX_PAYLOAD = 4;
   localparam int PAYLOAD_W   = 8 * MAX_PAYLOAD;

   localparam logic [7:0]  SYNC_BYTE     = 8'h55;
   localparam logic [7:0]  ANY_ID        = 8'hFE;
   localparam logic [7:0]  LEN_OVERHEAD  = 8'd3;
   localparam logic [15:0] TIMEOUT_RESET = 16'd250;

   // Frame positions (byte index within the frame)
   localparam logic [3:0] POS_ID      = 4'd2;
   localparam logic [3:0] POS_LEN     = 4'd3;
   localparam logic [3:0] POS_CMD     = 4'd4;
   localparam logic [3:0] POS_PAYLOAD = 4'd5;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SYNC    = 3'd1,
      ST_ID      = 3'd2,
      ST_LEN     = 3'd3,
      ST_CMD     = 3'd4,
      ST_SUM     = 3'd5,
      ST_TIMEOUT = 3'd6
   } status_type;

endpackage

@@ hdl/srfc_channels.sv @@
// Channel interfaces: request items, response items and the timeout register write.
interface srfc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data;
   logic [7:0] expected_id;
   logic [7:0] expected_command;
   logic [2:0] payload_len;

   modport source (output valid, cmd, data, expected_id, expected_command, payload_len,
                   input ready);
   modport sink   (input valid, cmd, data, expected_id, expected_command, payload_len,
                   output ready);
endinterface

interface srfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [srfc_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, status, payload, input ready);
   modport sink   (input valid, status, payload, output ready);
endinterface

interface srfc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] timeout_ticks;

   modport source (output valid, timeout_ticks, input ready);
   modport sink   (input valid, timeout_ticks, output ready);
endinterface

@@ hdl/servo_response_frame_checker.sv @@
// Top level: servo bus response frame checker.
//
//   channel   dir  handshake          payload
//   req_ch    in   valid/ready        cmd, data, expected_id, expected_command, payload_len
//   rsp_ch    out  valid/ready        status, payload
//   csr_ch    in   valid/ready        timeout_ticks (always ready)
//
// One item per cycle: the frame state is updated at the edge that accepts an
// item, any result is loaded into the output register at that same edge and
// is offered on rsp_ch from the next cycle.
// The output register decouples the sides; req_ch stalls only while a result
// waits and rsp_ch.ready is low.
// Reset (synchronous, active high) disarms the checker, empties the output
// register and sets the timeout to 250 ticks.
module servo_response_frame_checker (
   input  logic       clock,
   input  logic       reset,
   srfc_req_if.sink   req_ch,
   srfc_rsp_if.source rsp_ch,
   srfc_csr_if.sink   csr_ch
);

   // Frame state
   logic                    armed_ff,       armed_in;
   logic [3:0]              byte_count_ff,  byte_count_in;
   logic [7:0]              running_sum_ff, running_sum_in;
   logic [2:0]              first_error_ff, first_error_in;
   logic [srfc_pkg::PAYLOAD_W-1:0] payload_buf_ff, payload_buf_in;
   logic [7:0]              want_id_ff,     want_id_in;
   logic [7:0]              want_command_ff, want_command_in;
   logic [2:0]              want_length_ff, want_length_in;
   logic [15:0]             tick_count_ff,  tick_count_in;
   logic [15:0]             timeout_ff;

   // Output register
   logic                    rsp_valid_ff,   rsp_valid_in;
   logic [2:0]              rsp_status_ff,  rsp_status_in;
   logic [srfc_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   logic                    accept;
   logic                    res_fire;
   logic [2:0]              res_status;
   logic [srfc_pkg::PAYLOAD_W-1:0] res_payload;
   logic [3:0]              last_pos;
   logic [3:0]              pay_off;
   logic [1:0]              pay_idx;
   logic [7:0]              sum_next;
   logic [2:0]              err_code;
   logic                    err_hit;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready  = 1'b1;

   assign last_pos = srfc_pkg::POS_PAYLOAD + {1'b0, want_length_ff};
   assign pay_off  = byte_count_ff - srfc_pkg::POS_PAYLOAD;
   assign pay_idx  = pay_off[1:0];
   assign sum_next = running_sum_ff + req_ch.data;

   // Next frame state and result for the item on req_ch
   always_comb begin
      armed_in        = armed_ff;
      byte_count_in   = byte_count_ff;
      running_sum_in  = running_sum_ff;
      first_error_in  = first_error_ff;
      payload_buf_in  = payload_buf_ff;
      want_id_in      = want_id_ff;
      want_command_in = want_command_ff;
      want_length_in  = want_length_ff;
      tick_count_in   = tick_count_ff;
      res_fire        = 1'b0;
      res_status      = srfc_pkg::ST_OK;
      res_payload     = '0;
      err_hit         = 1'b0;
      err_code        = srfc_pkg::ST_OK;

      case (req_ch.cmd)
         srfc_pkg::CMD_START: begin
            // Clamp length into 1..MAX_PAYLOAD
            if (req_ch.payload_len == 3'd0) begin
               want_length_in = 3'd1;
            end else if (req_ch.payload_len > 3'(srfc_pkg::MAX_PAYLOAD)) begin
               want_length_in = 3'(srfc_pkg::MAX_PAYLOAD);
            end else begin
               want_length_in = req_ch.payload_len;
            end
            want_id_in      = req_ch.expected_id;
            want_command_in = req_ch.expected_command;
            armed_in        = 1'b1;
            byte_count_in   = 4'd0;
            running_sum_in  = 8'd0;
            first_error_in  = srfc_pkg::ST_OK;
            payload_buf_in  = '0;
            tick_count_in   = 16'd0;
         end
         srfc_pkg::CMD_TICK: begin
            if (armed_ff) begin
               tick_count_in = tick_count_ff + 16'd1;
               if (tick_count_in >= timeout_ff) begin
                  armed_in   = 1'b0;
                  res_fire   = 1'b1;
                  res_status = srfc_pkg::ST_TIMEOUT;
               end
            end
         end
         srfc_pkg::CMD_BYTE: begin
            if (armed_ff) begin
               byte_count_in = byte_count_ff + 4'd1;
               if (byte_count_ff < srfc_pkg::POS_ID) begin
                  // Sync bytes
                  err_hit  = (req_ch.data != srfc_pkg::SYNC_BYTE);
                  err_code = srfc_pkg::ST_SYNC;
               end else if (byte_count_ff < last_pos) begin
                  running_sum_in = sum_next;
                  if (byte_count_ff == srfc_pkg::POS_ID) begin
                     err_hit  = (want_id_ff != srfc_pkg::ANY_ID) &&
                                (req_ch.data != want_id_ff);
                     err_code = srfc_pkg::ST_ID;
                  end else if (byte_count_ff == srfc_pkg::POS_LEN) begin
                     err_hit  = (req_ch.data !=
                                 ({5'd0, want_length_ff} + srfc_pkg::LEN_OVERHEAD));
                     err_code = srfc_pkg::ST_LEN;
                  end else if (byte_count_ff == srfc_pkg::POS_CMD) begin
                     err_hit  = (req_ch.data != want_command_ff);
                     err_code = srfc_pkg::ST_CMD;
                  end else begin
                     payload_buf_in[{pay_idx, 3'b000} +: 8] =
                        payload_buf_ff[{pay_idx, 3'b000} +: 8] | req_ch.data;
                  end
               end else begin
                  // Checksum byte closes the frame
                  err_hit       = (req_ch.data != ~running_sum_ff);
                  err_code      = srfc_pkg::ST_SUM;
                  armed_in      = 1'b0;
                  byte_count_in = byte_count_ff;
                  res_fire      = 1'b1;
               end
               // Keep only the first error
               if (err_hit && (first_error_ff == srfc_pkg::ST_OK)) begin
                  first_error_in = err_code;
               end
               res_status  = first_error_in;
               res_payload = (first_error_in == srfc_pkg::ST_OK) ? payload_buf_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register load and drain
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      if (accept && res_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_payload_in = res_payload;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= srfc_pkg::TIMEOUT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            armed_ff <= armed_in;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            timeout_ff <= csr_ch.timeout_ticks;
         end
      end
   end

   // Frame data registers, only meaningful while armed, and the output status and payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         first_error_ff  <= first_error_in;
         payload_buf_ff  <= payload_buf_in;
         want_id_ff      <= want_id_in;
         want_command_ff <= want_command_in;
         want_length_ff  <= want_length_in;
         tick_count_ff   <= tick_count_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.payload = rsp_payload_ff;

endmodule

@@ hdl/srfc_checker.sv @@
// Port-level assertions for the servo response frame checker, with its bind.
`include "servo_response_frame_checker_macros.svh"

module srfc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [srfc_pkg::PAYLOAD_W-1:0] rsp_payload
);

   logic req_acc;
   logic rsp_stall;

   assign req_acc   = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A stalled result holds
   `SRFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_payload))
   // Payload is zero on any failing status
   `SRFC_ASSERT_IMP(a_err_zero_payload, clock, reset, rsp_valid && (rsp_status != srfc_pkg::ST_OK), rsp_payload == '0)
   // Input stalls only behind a waiting result
   `SRFC_ASSERT_IMP(a_ready_only_on_stall, clock, reset, !req_ready, rsp_stall)
   // A new result follows an accepted byte or tick item
   `SRFC_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_acc && (req_cmd != srfc_pkg::CMD_START)))

endmodule

bind servo_response_frame_checker srfc_checker u_srfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_cmd     (req_ch.cmd),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_payload (rsp_ch.payload)
);
